### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/art_pkg.sv
// ----------------------------------------------------------------------------
// ack retransmit table package
// shared constants: function codes, result kinds, register indexes, defaults
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int HANDLE_BITS_DEF   = 8;

   localparam logic [1:0] FN_SEND = 2'd0;
   localparam logic [1:0] FN_TICK = 2'd1;
   localparam logic [1:0] FN_ACK  = 2'd2;

   localparam logic [2:0] KIND_TX     = 3'd0;
   localparam logic [2:0] KIND_RETX   = 3'd1;
   localparam logic [2:0] KIND_GIVEUP = 3'd2;
   localparam logic [2:0] KIND_ACKCLR = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;
   localparam logic [2:0] KIND_TERR   = 3'd5;

   localparam logic CSR_ACK_TIMEOUT = 1'b0;
   localparam logic CSR_MAX_RETRIES = 1'b1;

   localparam logic [15:0] ACK_TIMEOUT_RST = 16'd100;
   localparam logic [3:0]  MAX_RETRIES_RST = 4'd3;

endpackage

### design/ack_retransmit_table.sv
// ----------------------------------------------------------------------------
// ack retransmit table
// pending acknowledgement table indexed by transaction id
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one item: a send, a timeout tick or a received ack.
//   rsp_* returns result items; rsp_last marks the final one of an item.
//   csr_* writes ack_timeout_ms (index 0) and max_retries (index 1); the user
//   is to write them only while idle, as the block itself does no check.
// sequencing:
//   send and ack: one result, loaded from EMIT or ACK once the output frees.
//   tick: the walk steps through the entries by the single table memory
//   read port, one entry a cycle save where it pauses (see stalls).
//   req_ready is high only while the sequencer is idle; an item is taken
//   even while a finished result still waits in the output register.
// reset:
//   pending and timed bits clear at once, last id goes to 0, registers take
//   their defaults; the memory needs no clearing pass.
// stalls:
//   a low rsp_ready holds the output register; the walk pauses on an entry
//   that has a result until the register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ack_retransmit_table #(
   parameter int TABLE_ENTRIES = art_pkg::TABLE_ENTRIES_DEF,
   parameter int HANDLE_BITS   = art_pkg::HANDLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic                   req_is_reply,
   input  logic                   req_wants_ack,
   input  logic [3:0]             req_trans_id,
   input  logic [HANDLE_BITS-1:0] req_msg_handle,
   input  logic [31:0]            req_now_ms,
   input  logic                   req_time_valid,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_kind,
   output logic [3:0]             rsp_out_id,
   output logic [HANDLE_BITS-1:0] rsp_out_handle,
   output logic                   rsp_ack_reply_flag,
   output logic                   rsp_overwrote,
   output logic                   rsp_last,

   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WORD_W = 4 + 32 + HANDLE_BITS;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [5:0] ENTRIES6 = 6'(TABLE_ENTRIES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EMIT = 3'd1;
   localparam logic [2:0] ST_ACK  = 3'd2;
   localparam logic [2:0] ST_TICK = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   function automatic logic [3:0] id_mod(input logic [3:0] v);
      logic [5:0] r;
      r = 6'(v);
      for (int k = 0; k < 8; k++) begin
         if (r >= ENTRIES6) begin
            r = r - ENTRIES6;
         end
      end
      return r[3:0];
   endfunction

   // state and configuration
   logic [2:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [31:0]            now_ff, now_in;
   logic [31:0]            nd_ff, nd_in;
   logic [3:0]             last_id_ff, last_id_in;
   logic [15:0]            timeout_ff;
   logic [3:0]             retries_cfg_ff;
   logic [TABLE_ENTRIES-1:0] pend_ff, pend_in;
   logic [TABLE_ENTRIES-1:0] timed_ff, timed_in;

   // staged single result
   logic [2:0]             stg_kind_ff, stg_kind_in;
   logic [3:0]             stg_id_ff, stg_id_in;
   logic [HANDLE_BITS-1:0] stg_handle_ff, stg_handle_in;
   logic                   stg_ackr_ff, stg_ackr_in;
   logic                   stg_ow_ff, stg_ow_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_kind_ff, rsp_kind_in;
   logic [3:0]             rsp_id_ff, rsp_id_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic                   rsp_ackr_ff, rsp_ackr_in;
   logic                   rsp_ow_ff, rsp_ow_in;
   logic                   rsp_last_ff, rsp_last_in;

   // table memory: retries, deadline, handle
   logic [WORD_W-1:0]      mem [TABLE_ENTRIES];
   logic [WORD_W-1:0]      rd_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [WORD_W-1:0]      mem_wdata;

   logic [3:0]             rd_retries;
   logic [31:0]            rd_deadline;
   logic [HANDLE_BITS-1:0] rd_handle;
   logic [3:0]             tid_mod;
   logic [IDX_W-1:0]       tid_idx;
   logic [5:0]             next_id6;
   logic [IDX_W-1:0]       send_idx;
   logic [5:0]             idx_ext;
   logic                   out_free;
   logic                   load;
   logic                   hit;
   logic                   give_up_now;

   assign rd_retries  = rd_ff[WORD_W-1 -: 4];
   assign rd_deadline = rd_ff[HANDLE_BITS +: 32];
   assign rd_handle   = rd_ff[HANDLE_BITS-1:0];
   assign tid_mod     = id_mod(req_trans_id);
   assign tid_idx     = IDX_W'(tid_mod);
   assign idx_ext     = 6'(idx_ff);
   assign send_idx    = next_id6[IDX_W-1:0];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);
   assign hit         = pend_ff[idx_ff] && timed_ff[idx_ff] && (now_ff >= rd_deadline);

   always_comb begin
      next_id6 = 6'(last_id_ff) + 6'd1;
      if (next_id6 >= ENTRIES6) begin
         next_id6 = next_id6 - ENTRIES6;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      now_in        = now_ff;
      nd_in         = nd_ff;
      last_id_in    = last_id_ff;
      pend_in       = pend_ff;
      timed_in      = timed_ff;
      stg_kind_in   = stg_kind_ff;
      stg_id_in     = stg_id_ff;
      stg_handle_in = stg_handle_ff;
      stg_ackr_in   = stg_ackr_ff;
      stg_ow_in     = stg_ow_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff;
      mem_wdata     = rd_ff;
      load          = 1'b0;
      give_up_now   = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_ackr_in   = rsp_ackr_ff;
      rsp_ow_in     = rsp_ow_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in = req_now_ms;
               nd_in  = req_now_ms + 32'(timeout_ff);
               case (req_func)
                  art_pkg::FN_SEND: begin
                     stg_kind_in   = art_pkg::KIND_TX;
                     stg_handle_in = req_msg_handle;
                     state_in      = ST_EMIT;
                     if (req_is_reply) begin
                        stg_id_in   = tid_mod;
                        stg_ackr_in = 1'b1;
                        stg_ow_in   = 1'b0;
                     end else begin
                        last_id_in  = next_id6[3:0];
                        stg_id_in   = next_id6[3:0];
                        stg_ackr_in = 1'b0;
                        stg_ow_in   = 1'b0;
                        if (req_wants_ack) begin
                           stg_ow_in          = pend_ff[send_idx];
                           pend_in[send_idx]  = 1'b1;
                           timed_in[send_idx] = req_time_valid;
                           mem_we             = 1'b1;
                           mem_waddr          = send_idx;
                           mem_wdata          = {retries_cfg_ff,
                                                 req_time_valid ? nd_in : 32'd0,
                                                 req_msg_handle};
                        end
                     end
                  end
                  art_pkg::FN_TICK: begin
                     if (!req_time_valid && (|(pend_ff & timed_ff))) begin
                        stg_kind_in   = art_pkg::KIND_TERR;
                        stg_id_in     = 4'd0;
                        stg_handle_in = '0;
                        stg_ackr_in   = 1'b0;
                        stg_ow_in     = 1'b0;
                        state_in      = ST_EMIT;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_TICK;
                     end
                  end
                  art_pkg::FN_ACK: begin
                     idx_in   = tid_idx;
                     state_in = ST_ACK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_kind_in   = stg_kind_ff;
               rsp_id_in     = stg_id_ff;
               rsp_handle_in = stg_handle_ff;
               rsp_ackr_in   = stg_ackr_ff;
               rsp_ow_in     = stg_ow_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_ACK: begin
            if (out_free) begin
               load             = 1'b1;
               rsp_kind_in      = art_pkg::KIND_ACKCLR;
               rsp_id_in        = idx_ext[3:0];
               rsp_handle_in    = pend_ff[idx_ff] ? rd_handle : '0;
               rsp_ackr_in      = 1'b0;
               rsp_ow_in        = 1'b0;
               rsp_last_in      = 1'b1;
               pend_in[idx_ff]  = 1'b0;
               timed_in[idx_ff] = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (!hit || out_free) begin
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
            if (hit && out_free) begin
               load          = 1'b1;
               rsp_id_in     = idx_ext[3:0];
               rsp_handle_in = rd_handle;
               rsp_ackr_in   = 1'b0;
               rsp_ow_in     = 1'b0;
               rsp_last_in   = 1'b0;
               if (rd_retries != 4'd0) begin
                  rsp_kind_in = art_pkg::KIND_RETX;
                  mem_we      = 1'b1;
                  mem_wdata   = {rd_retries - 4'd1, nd_ff, rd_handle};
               end else begin
                  rsp_kind_in      = art_pkg::KIND_GIVEUP;
                  give_up_now      = 1'b1;
                  pend_in[idx_ff]  = 1'b0;
                  timed_in[idx_ff] = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_kind_in   = art_pkg::KIND_DONE;
               rsp_id_in     = 4'd0;
               rsp_handle_in = '0;
               rsp_ackr_in   = 1'b0;
               rsp_ow_in     = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rd_addr      = idx_in;
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         last_id_ff     <= 4'd0;
         pend_ff        <= '0;
         timed_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         timeout_ff     <= art_pkg::ACK_TIMEOUT_RST;
         retries_cfg_ff <= art_pkg::MAX_RETRIES_RST;
      end else begin
         state_ff     <= state_in;
         last_id_ff   <= last_id_in;
         pend_ff      <= pend_in;
         timed_ff     <= timed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               art_pkg::CSR_ACK_TIMEOUT: timeout_ff     <= csr_wdata;
               art_pkg::CSR_MAX_RETRIES: retries_cfg_ff <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      now_ff        <= now_in;
      nd_ff         <= nd_in;
      stg_kind_ff   <= stg_kind_in;
      stg_id_ff     <= stg_id_in;
      stg_handle_ff <= stg_handle_in;
      stg_ackr_ff   <= stg_ackr_in;
      stg_ow_ff     <= stg_ow_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_ackr_ff   <= rsp_ackr_in;
      rsp_ow_ff     <= rsp_ow_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_out_id         = rsp_id_ff;
   assign rsp_out_handle     = rsp_handle_ff;
   assign rsp_ack_reply_flag = rsp_ackr_ff;
   assign rsp_overwrote      = rsp_ow_ff;
   assign rsp_last           = rsp_last_ff;

   `ASSERT_NXT(a_tick_walks_on, clock, reset, (state_ff == ST_TICK), (state_ff == ST_TICK || state_ff == ST_DONE), "tick walk left early")
   `ASSERT_NXT(a_giveup_clears, clock, reset, give_up_now, !pend_ff[$past(idx_ff)], "given up entry still pending")
   `ASSERT_IMP(a_walk_not_last, clock, reset, (rsp_valid_ff && (rsp_kind_ff == art_pkg::KIND_RETX || rsp_kind_ff == art_pkg::KIND_GIVEUP)), !rsp_last_ff, "walk result marked last")
   `ASSERT_IMP(a_reply_on_tx, clock, reset, (rsp_valid_ff && rsp_ackr_ff), (rsp_kind_ff == art_pkg::KIND_TX && !rsp_ow_ff), "ack reply flag on wrong kind")

endmodule
